[rtl/wfba_pkg.sv]
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared widths, codes and types of the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

  localparam int unsigned MaxBlocks = 16;
  localparam int unsigned W         = 21;
  localparam int unsigned PosW      = 8;
  localparam logic [W-1:0] TotalSizeReset = 21'd65536;

  localparam logic [1:0] ReqAlloc  = 2'd0;
  localparam logic [1:0] ReqFree   = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;
  localparam logic [1:0] ReqClear  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoGap    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [W-1:0] addr;
    logic [W-1:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    CellHold,
    CellRotate,
    CellInsert,
    CellDelete
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e      mode;
    logic [PosW-1:0] pos;
  } cell_op_t;

endpackage

[rtl/worst_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_core
// Worst-fit allocator over an address-ordered table kept in a row of cells.
//
//   channel  dir  handshake                fields
//   req      in   req_valid_i/req_ready_o  req_type, req_addr, req_size
//   rsp      out  rsp_valid_o/rsp_ready_i  status, block_addr, blk_size,
//                                          free_space, max_free_block
//   cfg      in   cfg_valid_i/cfg_ready_o  cfg_data_i (total_size)
//
// A request is taken in idle, then the cell row rotates once to find the gap
// or entry, the Modify state inserts, deletes or clears, and a second rotation
// sums the gaps and loads the response register on its last step.
// The core is back in idle, ready for the next request, in the same cycle
// that the response becomes valid.
// Reset empties the table at once. A stalled response holds the last step.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_core #(
  parameter int unsigned MaxBlocks = wfba_pkg::MaxBlocks
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [wfba_pkg::W-1:0] req_addr_i,
  input  logic [wfba_pkg::W-1:0] req_size_i,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output logic [1:0]             status_o,
  output logic [wfba_pkg::W-1:0] block_addr_o,
  output logic [wfba_pkg::W-1:0] blk_size_o,
  output logic [wfba_pkg::W-1:0] free_space_o,
  output logic [wfba_pkg::W-1:0] max_free_block_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [wfba_pkg::W-1:0] cfg_data_i
);

  localparam int unsigned W    = wfba_pkg::W;
  localparam int unsigned KW   = $clog2(MaxBlocks + 1);
  localparam int unsigned SumW = W + KW;
  localparam int unsigned PosW = wfba_pkg::PosW;

  typedef enum logic [2:0] {
    Idle,
    Scan1,
    Modify,
    Scan2
  } state_e;

  state_e state_q;
  logic [KW-1:0] k_q, count_q;
  logic [W:0] prev_end_q;
  logic [W-1:0] total_q;
  logic [1:0] type_q;
  logic [W-1:0] raddr_q, rsize_q;
  logic [PosW-1:0] best_q, fidx_q;
  logic [W-1:0] best_start_q, best_len_q;
  logic found_q;
  wfba_pkg::entry_t fent_q;
  logic [SumW-1:0] sum_q;
  logic [W-1:0] max_q;
  logic [1:0] st_q;
  logic [W-1:0] oaddr_q, osize_q;
  logic rsp_valid_q;
  logic [1:0] rsp_status_q;
  logic [W-1:0] rsp_addr_q, rsp_size_q, rsp_free_q, rsp_max_q;

  wfba_pkg::entry_t ent[MaxBlocks];
  wfba_pkg::entry_t new_ent;
  wfba_pkg::cell_op_t op;

  logic gap_en, ent_en, last;
  logic [W:0] hi, head_end, rend;
  logic [W-1:0] len;
  logic alloc_ok, free_ok;
  logic [SumW-1:0] sum_nx;
  logic [W-1:0] max_nx;
  logic rsp_load;
  logic [1:0] mod_st;
  logic [W-1:0] mod_addr, mod_size;

  assign req_ready_o      = (state_q == Idle);
  assign cfg_ready_o      = 1'b1;
  assign rsp_valid_o      = rsp_valid_q;
  assign status_o         = rsp_status_q;
  assign block_addr_o     = rsp_addr_q;
  assign blk_size_o       = rsp_size_q;
  assign free_space_o     = rsp_free_q;
  assign max_free_block_o = rsp_max_q;

  assign gap_en   = (k_q <= count_q);
  assign ent_en   = (k_q < count_q);
  assign last     = (k_q == KW'(MaxBlocks));
  assign hi       = (k_q == count_q) ? {1'b0, total_q} : {1'b0, ent[0].addr};
  assign len      = (hi > prev_end_q) ? W'(hi - prev_end_q) : '0;
  assign head_end = {1'b0, ent[0].addr} + {1'b0, ent[0].size};
  assign rend     = {1'b0, raddr_q} + {1'b0, rsize_q};
  assign sum_nx   = sum_q + (gap_en ? SumW'(len) : '0);
  assign max_nx   = (gap_en && (len > max_q)) ? len : max_q;
  assign rsp_load = (state_q == Scan2) && last && (!rsp_valid_q || rsp_ready_i);

  assign alloc_ok = (type_q == wfba_pkg::ReqAlloc) && (count_q < KW'(MaxBlocks)) &&
                    (best_len_q >= rsize_q);
  assign free_ok  = (type_q == wfba_pkg::ReqFree) && found_q;
  assign new_ent  = '{addr: best_start_q, size: rsize_q};

  always_comb begin
    op = '{mode: wfba_pkg::CellHold, pos: '0};
    case (state_q)
      Scan1, Scan2: begin
        if (!last) begin
          op.mode = wfba_pkg::CellRotate;
        end
      end
      Modify: begin
        if (alloc_ok) begin
          op = '{mode: wfba_pkg::CellInsert, pos: best_q};
        end else if (free_ok) begin
          op = '{mode: wfba_pkg::CellDelete, pos: fidx_q};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mod_st   = wfba_pkg::StOk;
    mod_addr = '0;
    mod_size = '0;
    case (type_q)
      wfba_pkg::ReqAlloc: begin
        if (count_q >= KW'(MaxBlocks)) begin
          mod_st = wfba_pkg::StFull;
        end else if (!alloc_ok) begin
          mod_st = wfba_pkg::StNoGap;
        end else begin
          mod_addr = best_start_q;
          mod_size = rsize_q;
        end
      end
      wfba_pkg::ReqFree: begin
        if (free_ok) begin
          mod_addr = raddr_q;
          mod_size = rsize_q;
        end else begin
          mod_st = wfba_pkg::StNotFound;
        end
      end
      wfba_pkg::ReqLookup: begin
        if (found_q) begin
          mod_addr = fent_q.addr;
          mod_size = fent_q.size;
        end else begin
          mod_st = wfba_pkg::StNotFound;
        end
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < MaxBlocks; j++) begin : g_cell
    localparam int unsigned Nxt = (j + 1) % MaxBlocks;
    wfba_cell #(.Idx(j)) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .new_i  (new_ent),
      .prev_i ((j == 0) ? new_ent : ent[(j == 0) ? 0 : j - 1]),
      .next_i (ent[Nxt]),
      .ent_o  (ent[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      total_q     <= wfba_pkg::TotalSizeReset;
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        Idle: begin
          if (req_valid_i) begin
            type_q       <= req_type_i;
            raddr_q      <= req_addr_i;
            rsize_q      <= req_size_i;
            k_q          <= '0;
            prev_end_q   <= '0;
            best_q       <= '0;
            best_start_q <= '0;
            best_len_q   <= '0;
            found_q      <= 1'b0;
            fidx_q       <= '0;
            fent_q       <= '0;
            state_q      <= Scan1;
          end
        end
        Scan1: begin
          if (gap_en && (len > best_len_q)) begin
            best_len_q   <= len;
            best_q       <= PosW'(k_q);
            best_start_q <= W'(prev_end_q);
          end
          if (ent_en) begin
            prev_end_q <= head_end;
            if (!found_q) begin
              if ((type_q == wfba_pkg::ReqFree) && (ent[0].addr == raddr_q) &&
                  (ent[0].size == rsize_q)) begin
                found_q <= 1'b1;
                fidx_q  <= PosW'(k_q);
              end
              if ((type_q == wfba_pkg::ReqLookup) && (ent[0].addr <= raddr_q) &&
                  (head_end >= rend)) begin
                found_q <= 1'b1;
                fent_q  <= ent[0];
              end
            end
          end
          k_q <= k_q + KW'(1);
          if (last) begin
            state_q <= Modify;
          end
        end
        Modify: begin
          st_q    <= mod_st;
          oaddr_q <= mod_addr;
          osize_q <= mod_size;
          if (alloc_ok) begin
            count_q <= count_q + KW'(1);
          end else if (free_ok) begin
            count_q <= count_q - KW'(1);
          end else if (type_q == wfba_pkg::ReqClear) begin
            count_q <= '0;
          end
          k_q        <= '0;
          prev_end_q <= '0;
          sum_q      <= '0;
          max_q      <= '0;
          state_q    <= Scan2;
        end
        Scan2: begin
          if (!last || !rsp_valid_q || rsp_ready_i) begin
            sum_q <= sum_nx;
            max_q <= max_nx;
            if (ent_en) begin
              prev_end_q <= head_end;
            end
            k_q <= k_q + KW'(1);
            if (last) begin
              rsp_status_q <= st_q;
              rsp_addr_q   <= oaddr_q;
              rsp_size_q   <= osize_q;
              rsp_free_q   <= (sum_nx > SumW'({W{1'b1}})) ? {W{1'b1}} : W'(sum_nx);
              rsp_max_q    <= max_nx;
              state_q      <= Idle;
            end
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= KW'(MaxBlocks))
    else $error("block count above table depth");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request taken while busy");

  a_rsp_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == Scan2))
    else $error("response loaded outside final scan");

endmodule

[rtl/wfba_cell.sv]
// ----------------------------------------------------------------------------
// wfba_cell
// One table slot: holds an entry and takes a neighbor's entry or the new
// entry on rotate, insert or delete.
// ----------------------------------------------------------------------------
module wfba_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic              clk_i,
  input  wfba_pkg::cell_op_t op_i,
  input  wfba_pkg::entry_t  new_i,
  input  wfba_pkg::entry_t  prev_i,
  input  wfba_pkg::entry_t  next_i,
  output wfba_pkg::entry_t  ent_o
);

  wfba_pkg::entry_t ent_q;
  logic [wfba_pkg::PosW-1:0] idx;

  assign idx   = wfba_pkg::PosW'(Idx);
  assign ent_o = ent_q;

  always_ff @(posedge clk_i) begin
    case (op_i.mode)
      wfba_pkg::CellRotate: ent_q <= next_i;
      wfba_pkg::CellInsert: begin
        if (idx > op_i.pos) begin
          ent_q <= prev_i;
        end else if (idx == op_i.pos) begin
          ent_q <= new_i;
        end
      end
      wfba_pkg::CellDelete: begin
        if (idx >= op_i.pos) begin
          ent_q <= next_i;
        end
      end
      default: ;
    endcase
  end

endmodule

[verif/tb_worst_fit_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_worst_fit_block_allocator_core
// Drives alloc, free, lookup and clear requests with random idling on both
// sides, predicts each response from a behavioral table model and compares
// every field in order. Region size is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_worst_fit_block_allocator_core;

  localparam int unsigned W         = wfba_pkg::W;
  localparam int unsigned MaxBlocks = wfba_pkg::MaxBlocks;

  typedef struct {
    logic [1:0]   kind;
    logic [W-1:0] addr;
    logic [W-1:0] size;
  } alloc_req_t;

  typedef struct {
    logic [1:0]   status;
    logic [W-1:0] baddr;
    logic [W-1:0] bsize;
    logic [W-1:0] free_sum;
    logic [W-1:0] max_gap;
  } alloc_rsp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         req_valid_i = 1'b0;
  logic         req_ready_o;
  logic [1:0]   req_type_i = '0;
  logic [W-1:0] req_addr_i = '0;
  logic [W-1:0] req_size_i = '0;
  logic         rsp_valid_o;
  logic         rsp_ready_i = 1'b0;
  logic [1:0]   status_o;
  logic [W-1:0] block_addr_o, blk_size_o, free_space_o, max_free_block_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [W-1:0] cfg_data_i = '0;

  worst_fit_block_allocator_core dut (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .req_type_i, .req_addr_i,
    .req_size_i, .rsp_valid_o, .rsp_ready_i, .status_o, .block_addr_o,
    .blk_size_o, .free_space_o, .max_free_block_o, .cfg_valid_i,
    .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // allocator model state
  logic [W-1:0] tbl_addr [MaxBlocks+1];
  logic [W-1:0] tbl_size [MaxBlocks+1];
  int           tbl_cnt;
  logic [W-1:0] region_size;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  logic stim_done = 1'b0;

  function automatic longint gap_len(int g);
    longint lo, hi;
    lo = (g == 0) ? 0 : longint'(tbl_addr[g-1]) + tbl_size[g-1];
    hi = (g == tbl_cnt) ? longint'(region_size) : longint'(tbl_addr[g]);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic alloc_rsp_t apply_request(alloc_req_t r);
    alloc_rsp_t o;
    int best;
    longint blen, l, sum, mx, a;
    o = '{wfba_pkg::StOk, '0, '0, '0, '0};
    case (r.kind)
      wfba_pkg::ReqAlloc: begin
        if (tbl_cnt >= MaxBlocks) o.status = wfba_pkg::StFull;
        else begin
          best = 0;
          blen = gap_len(0);
          for (int g = 1; g <= tbl_cnt; g++) begin
            l = gap_len(g);
            if (l > blen) begin
              blen = l;
              best = g;
            end
          end
          if (blen < r.size) o.status = wfba_pkg::StNoGap;
          else begin
            a = (best == 0) ? 0 : longint'(tbl_addr[best-1]) + tbl_size[best-1];
            for (int i = tbl_cnt; i > best; i--) begin
              tbl_addr[i] = tbl_addr[i-1];
              tbl_size[i] = tbl_size[i-1];
            end
            tbl_addr[best] = a[W-1:0];
            tbl_size[best] = r.size;
            tbl_cnt++;
            o.baddr = a[W-1:0];
            o.bsize = r.size;
          end
        end
      end
      wfba_pkg::ReqFree: begin
        o.status = wfba_pkg::StNotFound;
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl_addr[i] == r.addr && tbl_size[i] == r.size) begin
            o = '{wfba_pkg::StOk, r.addr, r.size, '0, '0};
            for (int j = i; j + 1 < tbl_cnt; j++) begin
              tbl_addr[j] = tbl_addr[j+1];
              tbl_size[j] = tbl_size[j+1];
            end
            tbl_cnt--;
            break;
          end
        end
      end
      wfba_pkg::ReqLookup: begin
        o.status = wfba_pkg::StNotFound;
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl_addr[i] <= r.addr &&
              longint'(tbl_addr[i]) + tbl_size[i] >= longint'(r.addr) + r.size) begin
            o = '{wfba_pkg::StOk, tbl_addr[i], tbl_size[i], '0, '0};
            break;
          end
        end
      end
      default: tbl_cnt = 0;
    endcase
    sum = 0;
    mx = 0;
    for (int g = 0; g <= tbl_cnt; g++) begin
      l = gap_len(g);
      sum += l;
      if (l > mx) mx = l;
    end
    if (sum > 64'h1FFFFF) sum = 64'h1FFFFF;
    o.free_sum = sum[W-1:0];
    o.max_gap = mx[W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        expected_rsps.push_back(apply_request('{req_type_i, req_addr_i, req_size_i}));
      end
      if (!req_valid_i || req_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_valid_i <= 1'b1;
          req_type_i <= pending_reqs[0].kind;
          req_addr_i <= pending_reqs[0].addr;
          req_size_i <= pending_reqs[0].size;
          void'(pending_reqs.pop_front());
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver holdoff counter
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    alloc_rsp_t w;
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 0, 0);
        end else begin
          w = expected_rsps.pop_front();
          if (status_o !== w.status) report_mismatch("status", status_o, w.status);
          if (block_addr_o !== w.baddr) report_mismatch("block_addr", block_addr_o, w.baddr);
          if (blk_size_o !== w.bsize) report_mismatch("blk_size", blk_size_o, w.bsize);
          if (free_space_o !== w.free_sum)
            report_mismatch("free_space", free_space_o, w.free_sum);
          if (max_free_block_o !== w.max_gap)
            report_mismatch("max_free_block", max_free_block_o, w.max_gap);
        end
      end
      rsp_ready_i <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [W-1:0] rand_size();
    case ($urandom_range(9))
      0: return W'($urandom_range(21'h1FFFFF));
      1: return '0;
      2, 3: return W'($urandom_range(region_size));
      default: return W'($urandom_range(4096));
    endcase
  endfunction

  task automatic push_req(logic [1:0] k, logic [W-1:0] a, logic [W-1:0] s);
    pending_reqs.push_back('{k, a, s});
  endtask

  // sequences built mostly from currently held blocks so frees/lookups hit
  task automatic push_random(int n);
    logic [W-1:0] held_a [$];
    logic [W-1:0] held_s [$];
    logic [W-1:0] sa, ss;
    int k, idx;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 40) begin
        push_req(wfba_pkg::ReqAlloc, W'($urandom), rand_size());
      end else if (k < 97) begin
        idx = $urandom_range(MaxBlocks + 3);
        sa = W'($urandom_range(21'h1FFFFF));
        ss = rand_size();
        if (idx < tbl_cnt && $urandom_range(3) != 0) begin
          sa = tbl_addr[idx];
          ss = tbl_size[idx];
          if (k >= 70 && ss > 0) begin
            sa = sa + W'($urandom_range(ss));
            ss = W'($urandom_range(tbl_addr[idx] + tbl_size[idx] - sa));
          end
        end
        push_req(k < 70 ? wfba_pkg::ReqFree : wfba_pkg::ReqLookup, sa, ss);
      end else begin
        push_req(wfba_pkg::ReqClear, W'($urandom), W'($urandom));
      end
      // keep the model in step so the next picks see the table
      wait_model();
    end
  endtask

  // sampled at the falling edge so driver and monitor updates have settled
  task automatic wait_model();
    while (pending_reqs.size() > 0 || req_valid_i || expected_rsps.size() > 0)
      @(negedge clk_i);
  endtask

  task automatic write_region(logic [W-1:0] v);
    wait_model();
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    region_size = v;
  endtask

  initial begin
    tbl_cnt = 0;
    region_size = wfba_pkg::TotalSizeReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    push_req(wfba_pkg::ReqFree, '0, '0);
    push_req(wfba_pkg::ReqLookup, '0, '0);
    push_req(wfba_pkg::ReqAlloc, '0, 21'h1FFFFF);
    push_req(wfba_pkg::ReqAlloc, '0, '0);
    push_req(wfba_pkg::ReqAlloc, 21'h1FFFFF, 21'd100);
    push_req(wfba_pkg::ReqAlloc, '0, 21'd200);
    push_req(wfba_pkg::ReqLookup, '0, '0);
    push_req(wfba_pkg::ReqLookup, 21'd50, 21'd50);
    push_req(wfba_pkg::ReqFree, '0, 21'd100);
    push_req(wfba_pkg::ReqFree, '0, '0);
    push_req(wfba_pkg::ReqAlloc, '0, 21'd10);
    for (int i = 0; i < 14; i++) push_req(wfba_pkg::ReqAlloc, '0, 21'd1000);
    wait_model();
    push_req(wfba_pkg::ReqAlloc, '0, '0);
    push_req(wfba_pkg::ReqLookup, 21'h1FFFFF, 21'h1FFFFF);
    push_req(wfba_pkg::ReqFree, 21'h1FFFFF, 21'h1FFFFF);
    write_region(21'd8000);
    push_req(wfba_pkg::ReqLookup, '0, 21'd1);
    push_req(wfba_pkg::ReqClear, 21'h1FFFFF, 21'h1FFFFF);
    write_region(21'd0);
    push_req(wfba_pkg::ReqAlloc, '0, 21'd1);
    push_req(wfba_pkg::ReqAlloc, '0, '0);
    push_req(wfba_pkg::ReqClear, '0, '0);
    write_region(21'h100000);
    for (int i = 0; i < 6; i++) push_req(wfba_pkg::ReqAlloc, '0, 21'h40000);
    wait_model();
    write_region(21'h1FFFFF);
    // large sum saturation: region at max, blocks shrunk later
    send_idle_pct = 11;
    recv_idle_pct = 82;
    push_random(350);
    // long receiver holdoff while requests keep coming
    wait_model();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) push_req(wfba_pkg::ReqLookup, W'($urandom), W'($urandom));
    wait_model();
    write_region(21'd5000);
    send_idle_pct = 82;
    recv_idle_pct = 11;
    push_random(350);
    write_region(W'($urandom_range(21'h1FFFFF)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(300);
    write_region(wfba_pkg::TotalSizeReset);
    push_random(300);
    wait_model();
    repeat (80) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      report_mismatch("missing responses", 0, expected_rsps.size());
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/wfba_pkg.sv
rtl/wfba_cell.sv
rtl/worst_fit_block_allocator_core.sv
verif/tb_worst_fit_block_allocator_core.sv
